FILE: design/tcw_pkg.sv
package tcw_pkg;

    // Field widths fixed by the interface
    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 24;
    localparam int PANEL_W   = 9;
    localparam int CFG_IDX_W = 1;

    // Default panel limits
    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 256;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_ROWS    = 1'd1;

    localparam logic [PANEL_W-1:0] PANEL_COLUMNS_RESET = 9'd80;
    localparam logic [PANEL_W-1:0] PANEL_ROWS_RESET    = 9'd25;

    // Character codes
    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_FORE      = 8'h66;  // 'f'
    localparam logic [7:0] CHAR_BACK      = 8'h62;  // 'b'

    typedef struct packed {
        logic [7:0]                char_byte;
        logic                      first;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
    } tcw_char_t;

    typedef struct packed {
        logic [15:0]        cell_address;
        logic [7:0]         glyph_low_byte;
        logic [7:0]         glyph_high_byte;
        logic [COLOR_W-1:0] fg_color;
        logic               fg_write;
        logic [COLOR_W-1:0] bg_color;
        logic               bg_write;
    } tcw_cell_t;

    // Print request from the parser to the cell stage
    typedef struct packed {
        logic                      active;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [7:0]                ch;
        logic [COLOR_W-1:0]        fg_color;
        logic                      fg_on;
        logic [COLOR_W-1:0]        bg_color;
        logic                      bg_on;
    } tcw_print_t;

endpackage

FILE: design/tcw_char_reg.sv
module tcw_char_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_stall,
    input  tcw_pkg::tcw_char_t char_beat,
    input  logic              advance,
    output logic              held_valid,
    output tcw_pkg::tcw_char_t held_beat
);
    import tcw_pkg::*;

    logic      valid_reg;
    tcw_char_t beat_reg;

    // Full and not moving on: hold the sender off
    assign char_stall = valid_reg && !advance;
    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            beat_reg <= char_beat;
        end
    end

endmodule

FILE: design/tcw_parser.sv
module tcw_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  tcw_pkg::tcw_char_t beat,
    output tcw_pkg::tcw_print_t print_req
);
    import tcw_pkg::*;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_FG,
        MODE_BG
    } mode_t;

    logic signed [COORD_W-1:0] col_reg, col_next;
    logic signed [COORD_W-1:0] row_reg, row_next;
    logic signed [COORD_W-1:0] start_reg, start_next;
    mode_t                     mode_reg, mode_next, mode_cur;
    logic [31:0]               acc_reg, acc_next;
    logic [1:0]                cnt_reg, cnt_next;
    logic [COLOR_W-1:0]        fore_reg, fore_next;
    logic                      fore_on_reg, fore_on_next;
    logic [COLOR_W-1:0]        back_reg, back_next;
    logic                      back_on_reg, back_on_next;

    logic [4:0] hex;
    logic       run_normal;
    logic       do_print;
    logic       colour_on;

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= "0" && c <= "9")
        begin
            r = {1'b1, 4'(c - "0")};
        end
        else if (c >= "a" && c <= "f")
        begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end
        else if (c >= "A" && c <= "F")
        begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_inc(input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W-1:0] top;
        top = {1'b0, {(COORD_W-1){1'b1}}};
        return (v == top) ? v : v + $signed(COORD_W'(1));
    endfunction

    assign hex = hex_digit(beat.char_byte);

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        start_next   = start_reg;
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        fore_next    = fore_reg;
        fore_on_next = fore_on_reg;
        back_next    = back_reg;
        back_on_next = back_on_reg;
        run_normal   = 1'b0;
        do_print     = 1'b0;
        colour_on    = 1'b0;
        print_req    = '0;

        if (beat.first)
        begin
            col_next     = beat.origin_x;
            start_next   = beat.origin_x;
            row_next     = beat.origin_y;
            mode_next    = MODE_NORMAL;
            acc_next     = '0;
            cnt_next     = '0;
            fore_next    = '0;
            fore_on_next = 1'b0;
            back_next    = '0;
            back_on_next = 1'b0;
        end

        mode_cur = mode_next;
        case (mode_cur)
            MODE_FG, MODE_BG:
            begin
                if (hex[4])
                begin
                    acc_next = {acc_next[27:0], hex[3:0]};
                    if (cnt_next != 2'd3)
                    begin
                        cnt_next = cnt_next + 2'd1;
                    end
                end
                else
                begin
                    // Parse ends; a colour needs at least two digits and a positive value
                    colour_on = (cnt_next >= 2'd2) && (acc_next != '0) && !acc_next[31];
                    if (mode_cur == MODE_FG)
                    begin
                        fore_on_next = colour_on;
                        fore_next    = colour_on ? acc_next[COLOR_W-1:0] : '0;
                    end
                    else
                    begin
                        back_on_next = colour_on;
                        back_next    = colour_on ? acc_next[COLOR_W-1:0] : '0;
                    end
                    mode_next  = MODE_NORMAL;
                    run_normal = 1'b1;
                end
            end
            MODE_ESCAPE:
            begin
                mode_next = MODE_NORMAL;
                if (beat.char_byte == CHAR_FORE || beat.char_byte == CHAR_BACK)
                begin
                    mode_next = (beat.char_byte == CHAR_FORE) ? MODE_FG : MODE_BG;
                    acc_next  = '0;
                    cnt_next  = '0;
                end
                else if (beat.char_byte != CHAR_NUL)
                begin
                    do_print = 1'b1;
                end
            end
            default:
            begin
                run_normal = 1'b1;
            end
        endcase

        if (run_normal)
        begin
            if (beat.char_byte == CHAR_NUL)
            begin
                mode_next = MODE_NORMAL;
            end
            else if (beat.char_byte == CHAR_NEWLINE)
            begin
                col_next = start_next;
                row_next = sat_inc(row_next);
            end
            else if (beat.char_byte == CHAR_BACKSLASH)
            begin
                mode_next = MODE_ESCAPE;
            end
            else
            begin
                do_print = 1'b1;
            end
        end

        if (do_print)
        begin
            print_req.x = col_next;
            print_req.y = row_next;
            col_next    = sat_inc(col_next);
        end
        print_req.active   = fire && do_print;
        print_req.ch       = beat.char_byte;
        print_req.fg_color = fore_next;
        print_req.fg_on    = fore_on_next;
        print_req.bg_color = back_next;
        print_req.bg_on    = back_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            start_reg   <= '0;
            mode_reg    <= MODE_NORMAL;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            fore_reg    <= '0;
            fore_on_reg <= 1'b0;
            back_reg    <= '0;
            back_on_reg <= 1'b0;
        end
        else if (fire)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            start_reg   <= start_next;
            mode_reg    <= mode_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            fore_reg    <= fore_next;
            fore_on_reg <= fore_on_next;
            back_reg    <= back_next;
            back_on_reg <= back_on_next;
        end
    end

endmodule

FILE: design/tcw_cell_out.sv
module tcw_cell_out #(
    parameter int MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tcw_pkg::DEF_MAX_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcw_pkg::tcw_print_t              print_req,
    input  logic                             cfg_write_en,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcw_pkg::PANEL_W-1:0]      cfg_data,
    input  logic                             cell_stall,
    output logic                             cell_valid,
    output tcw_pkg::tcw_cell_t               cell_beat,
    output logic                             space
);
    import tcw_pkg::*;

    localparam int ROW_IW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PROD_W  = PANEL_W + ROW_IW;
    localparam logic [PANEL_W-1:0] COL_LIMIT = PANEL_W'(MAX_COLUMNS);
    localparam logic [PANEL_W-1:0] ROW_LIMIT = PANEL_W'(MAX_ROWS);

    logic [PANEL_W-1:0] columns_reg;
    logic [PANEL_W-1:0] rows_reg;
    logic               valid_reg;
    tcw_cell_t          cell_reg;

    logic [PANEL_W-1:0] cols;
    logic [PANEL_W-1:0] rows;
    logic               on_panel;
    logic [PROD_W-1:0]  row_base;
    tcw_cell_t          cell_next;

    assign cols = (columns_reg > COL_LIMIT) ? COL_LIMIT : columns_reg;
    assign rows = (rows_reg > ROW_LIMIT) ? ROW_LIMIT : rows_reg;

    assign on_panel = !print_req.x[COORD_W-1] && !print_req.y[COORD_W-1]
                   && (print_req.x < $signed(COORD_W'(cols)))
                   && (print_req.y < $signed(COORD_W'(rows)));

    // Row index fits ROW_IW bits whenever the cell is on the panel
    assign row_base = PROD_W'(cols) * PROD_W'(print_req.y[ROW_IW-1:0]);

    always_comb
    begin
        cell_next.cell_address    = 16'(print_req.x) + 16'(row_base);
        cell_next.glyph_low_byte  = {print_req.ch[3:0], 4'b0000};
        cell_next.glyph_high_byte = {print_req.ch[7:4], 4'b0000};
        cell_next.fg_color        = print_req.fg_on ? print_req.fg_color : '0;
        cell_next.fg_write        = print_req.fg_on;
        cell_next.bg_color        = print_req.bg_on ? print_req.bg_color : '0;
        cell_next.bg_write        = print_req.bg_on;
    end

    assign space      = !valid_reg || !cell_stall;
    assign cell_valid = valid_reg;
    assign cell_beat  = cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= PANEL_COLUMNS_RESET;
            rows_reg    <= PANEL_ROWS_RESET;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_PANEL_COLUMNS: columns_reg <= cfg_data;
                    REG_PANEL_ROWS:    rows_reg    <= cfg_data;
                    default:           ;
                endcase
            end
            if (space)
            begin
                valid_reg <= print_req.active && on_panel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (space && print_req.active && on_panel)
        begin
            cell_reg <= cell_next;
        end
    end

endmodule

FILE: design/text_cell_writer_color_escapes_top.sv
// Text cell writer with colour escapes.
// Character channel: char_valid / char_stall / char_beat, one string byte a beat;
// char_beat.first opens a string, loads the origin and clears both colours.
// Cell channel: cell_valid / cell_stall / cell_beat, one display-memory write per
// printed character that lands on the panel (address, glyph bytes, colours and
// their write enables). Newlines, escapes, hex digits, the terminating zero and
// clipped characters give no beat.
// Throughput: one byte per cycle unless cell_stall holds a full output register;
// set by the parser state update (cursor, escape mode, hex accumulator, colours).
// Path: an accepted byte passes through the input register, then the cell
// output register, which drives its cell beat.
// Stall: when cell_stall holds a full output register, the parser stops and
// char_stall rises the same cycle once the input register is full.
// Reset: rst_n is asynchronous; cursor, line start and colours clear, the
// parser returns to plain text, the panel resets to 80 x 25.
// Config: cfg_write_en / cfg_index / cfg_data write panel_columns (index 0) or
// panel_rows (index 1); write only while the block is idle.
module text_cell_writer_color_escapes_top #(
    parameter int MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tcw_pkg::DEF_MAX_ROWS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          char_valid,
    output logic                          char_stall,
    input  tcw_pkg::tcw_char_t            char_beat,
    output logic                          cell_valid,
    input  logic                          cell_stall,
    output tcw_pkg::tcw_cell_t            cell_beat,
    input  logic                          cfg_write_en,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcw_pkg::PANEL_W-1:0]   cfg_data
);
    import tcw_pkg::*;

    logic       held_valid;
    tcw_char_t  held_beat;
    logic       space;
    logic       fire;
    tcw_print_t print_req;

    // A held byte is processed whenever the output register can take a beat
    assign fire = held_valid && space;

    tcw_char_reg u_char_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat),
        .advance    (fire),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    // Cursor, escape and colour state; one byte per fire
    tcw_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .beat      (held_beat),
        .print_req (print_req)
    );

    // Clip, address and register the cell write
    tcw_cell_out #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_cell_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .print_req    (print_req),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_stall   (cell_stall),
        .cell_valid   (cell_valid),
        .cell_beat    (cell_beat),
        .space        (space)
    );

endmodule
